/* sv/uhte_pkg.sv */
// Package with shared types, constants and helpers for the hash table engine.
package uhte_pkg;

    localparam int NUM_BUCKETS_DEF = 64;
    localparam int CHAIN_DEPTH_DEF = 8;
    localparam int KEY_BITS_DEF    = 64;

    localparam logic [63:0] RESET_MULT_A  = 64'd1;
    localparam logic [63:0] RESET_ADD_B   = 64'd0;
    localparam logic [63:0] RESET_PRIME_P = 64'd18446744073709551557;
    localparam logic [6:0]  RESET_BUCKETS = 7'd5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_ALT    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_MULT_A  = 2'd0,
        CFG_ADD_B   = 2'd1,
        CFG_PRIME_P = 2'd2,
        CFG_BUCKETS = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key;
        logic [63:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [63:0] value_out;
        logic [5:0]  bucket_index;
        logic [9:0]  entry_count;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key;
        logic [63:0] value;
        logic [6:0]  bucket;
    } work_t;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_REDA,
        HS_REDB,
        HS_MUL,
        HS_ADDB,
        HS_BKT,
        HS_PUSH
    } hash_state_t;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_READ,
        BS_WAIT,
        BS_CHECK,
        BS_DONE
    } back_state_t;

    // Modular add for operands below m; m is nonzero.
    function automatic logic [63:0] add_mod(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] m);
        logic [64:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            if (s[64] || s[63:0] >= m)
            begin
                s = s - {1'b0, m};
            end
            add_mod = s[63:0];
        end
    endfunction

endpackage

/* sv/uhte_fifo.sv */
// Short queue between the hash front end and the table back end.
module uhte_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  uhte_pkg::work_t din,
    output logic           full,
    input  logic           pop,
    output uhte_pkg::work_t dout,
    output logic           empty
);
    import uhte_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    work_t           mem_reg [DEPTH];
    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   rptr_reg;
    logic [AW:0]     cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count past depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && empty) |=> $stable(rptr_reg)) else $error("read pointer moved on empty");
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !pop) |=> $stable(wptr_reg)) else $error("write on full queue");

endmodule

/* sv/uhte_hash.sv */
// Front end: takes requests, hashes to a bucket by bit-serial multiply mod p (wraps if p=0).
module uhte_hash #(
    parameter int NUM_BUCKETS = uhte_pkg::NUM_BUCKETS_DEF,
    parameter int KEY_BITS    = uhte_pkg::KEY_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  uhte_pkg::req_t   req,
    input  logic [63:0]      mult_a,
    input  logic [63:0]      add_b,
    input  logic [63:0]      prime_p,
    input  logic [6:0]       buckets,
    output logic             work_push,
    output uhte_pkg::work_t  work,
    input  logic             work_full
);
    import uhte_pkg::*;

    hash_state_t  state_reg, state_next;
    logic [1:0]   op_reg;
    logic [63:0]  key_reg;
    logic [63:0]  value_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  r_reg;
    logic [63:0]  red_reg;
    logic [6:0]   bit_reg;
    logic [6:0]   n_reg;
    logic [6:0]   bkt_reg;

    logic [63:0]  key_mask;
    logic [63:0]  dbl;
    logic [63:0]  step;
    logic [64:0]  rem_sh;
    logic [63:0]  src_bit_a;
    logic [63:0]  red_step;
    logic [63:0]  mult_partial;
    logic [63:0]  pp_ll_reg;
    logic [31:0]  pp_lh_reg;
    logic [31:0]  pp_hl_reg;

    assign key_mask = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);

    always_comb
    begin
        dbl  = add_mod(r_reg, r_reg, prime_p);
        step = key_reg[bit_reg[5:0]] ? add_mod(dbl, a_reg, prime_p) : dbl;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            HS_IDLE:  if (req_valid) state_next = HS_REDA;
            HS_REDA:  if (bit_reg == 7'd0) state_next = HS_REDB;
            HS_REDB:  if (bit_reg == 7'd0) state_next = (prime_p == '0) ? HS_ADDB : HS_MUL;
            HS_MUL:   if (bit_reg == 7'd0) state_next = HS_ADDB;
            HS_ADDB:  state_next = HS_BKT;
            HS_BKT:   if (r_reg < {57'd0, n_reg}) state_next = HS_PUSH;
            HS_PUSH:  if (!work_full) state_next = HS_IDLE;
            default:  state_next = HS_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = (state_reg == HS_IDLE);
        work_push = (state_reg == HS_PUSH) && !work_full;
        work.operation = op_reg;
        work.key       = key_reg;
        work.value     = value_reg;
        work.bucket    = bkt_reg;
    end

    // Restoring reduction of a mod p and b mod p, one bit of the source a cycle.
    always_comb
    begin
        src_bit_a = (state_reg == HS_REDA) ? a_reg : b_reg;
        rem_sh    = {red_reg, src_bit_a[bit_reg[5:0]]};
        red_step  = (rem_sh >= {1'b0, prime_p}) ? 64'(rem_sh - {1'b0, prime_p}) : rem_sh[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            HS_IDLE:
            begin
                op_reg    <= req.operation;
                key_reg   <= req.key & key_mask;
                value_reg <= req.value;
                a_reg     <= mult_a;
                b_reg     <= add_b;
                red_reg   <= '0;
                bit_reg   <= 7'd63;
                n_reg     <= (buckets == 7'd0) ? 7'd1 :
                             ({25'd0, buckets} > 32'(NUM_BUCKETS)) ? 7'(NUM_BUCKETS) : buckets;
            end
            HS_REDA, HS_REDB:
            begin
                red_reg <= (bit_reg == 7'd0) ? '0 : red_step;
                if (bit_reg == 7'd0 && prime_p != '0)
                begin
                    if (state_reg == HS_REDA)
                    begin
                        a_reg <= red_step;
                    end
                    else
                    begin
                        b_reg <= red_step;
                    end
                end
                bit_reg <= (bit_reg == 7'd0) ? 7'd63 : bit_reg - 7'd1;
                r_reg   <= '0;
            end
            HS_MUL:
            begin
                r_reg   <= step;
                bit_reg <= bit_reg - 7'd1;
            end
            HS_ADDB:
            begin
                if (prime_p == '0)
                begin
                    r_reg <= mult_partial + b_reg;
                end
                else
                begin
                    r_reg <= add_mod(r_reg, b_reg, prime_p);
                end
                bkt_reg <= '0;
                bit_reg <= 7'd63;
            end
            HS_BKT:
            begin
                // Reduce by n one shifted subtraction a cycle: r mod n by restoring division.
                if (r_reg >= ({57'd0, n_reg} << bit_reg[5:0]) &&
                    (({57'd0, n_reg} << bit_reg[5:0]) >> bit_reg[5:0]) == {57'd0, n_reg})
                begin
                    r_reg <= r_reg - ({57'd0, n_reg} << bit_reg[5:0]);
                end
                if (bit_reg != 7'd0)
                begin
                    bit_reg <= bit_reg - 7'd1;
                end
                bkt_reg <= r_reg[6:0];
            end
            HS_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Wrapping product for modulus zero, built from 32-bit partial products.
    always_ff @(posedge clk)
    begin
        pp_ll_reg <= a_reg[31:0] * key_reg[31:0];
        pp_lh_reg <= 32'(a_reg[31:0] * key_reg[63:32]);
        pp_hl_reg <= 32'(a_reg[63:32] * key_reg[31:0]);
    end
    assign mult_partial = pp_ll_reg + {pp_lh_reg + pp_hl_reg, 32'd0};

    a_push_state: assert property (@(posedge clk) disable iff (!rst_n)
        work_push |-> state_reg == HS_PUSH) else $error("push outside push state");
    a_bkt_range: assert property (@(posedge clk) disable iff (!rst_n)
        work_push |-> work.bucket < n_reg) else $error("bucket out of range");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready) else $error("took two requests");

endmodule

/* sv/uhte_table.sv */
// Back end: chain scan over the slot memories, update and result register.
module uhte_table #(
    parameter int NUM_BUCKETS = uhte_pkg::NUM_BUCKETS_DEF,
    parameter int CHAIN_DEPTH = uhte_pkg::CHAIN_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             work_empty,
    input  uhte_pkg::work_t  work,
    output logic             work_pop,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output uhte_pkg::rsp_t   rsp
);
    import uhte_pkg::*;

    localparam int SLOTS = NUM_BUCKETS * CHAIN_DEPTH;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(CHAIN_DEPTH + 1);
    localparam int TW    = $clog2(SLOTS + 1);

    logic [63:0]      key_mem [SLOTS];
    logic [63:0]      val_mem [SLOTS];
    logic             valid_mem [SLOTS];

    back_state_t      state_reg, state_next;
    logic [SW-1:0]    clr_reg;
    logic [CW-1:0]    idx_reg;
    logic [SW-1:0]    base_reg;
    logic             hit_reg;
    logic [SW-1:0]    hit_slot_reg;
    logic             free_reg;
    logic [SW-1:0]    free_slot_reg;
    logic [63:0]      rd_key_reg;
    logic [63:0]      rd_val_reg;
    logic             rd_valid_reg;
    logic [SW-1:0]    rd_slot_reg;
    logic [63:0]      val_mem_hit_reg;
    logic [TW-1:0]    total_reg;
    logic             out_valid_reg;
    rsp_t             out_reg;
    work_t            cur_reg;

    logic [SW-1:0]    cur_slot;
    logic             scan_last;
    logic             clr_last;
    logic             scan_match;
    logic             issue;
    logic             do_insert;
    logic             do_remove;
    status_t          status_next;
    logic [TW-1:0]    total_next;
    logic [63:0]      value_next;

    assign cur_slot   = base_reg + SW'(idx_reg);
    assign scan_last  = (idx_reg == CW'(CHAIN_DEPTH));
    assign clr_last   = (clr_reg == SW'(SLOTS - 1));
    assign scan_match = rd_valid_reg && (rd_key_reg == cur_reg.key);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_CLEAR: if (clr_last) state_next = BS_IDLE;
            BS_IDLE:  if (!work_empty) state_next = BS_READ;
            BS_READ:  state_next = scan_last ? BS_DONE : BS_WAIT;
            BS_WAIT:  state_next = BS_CHECK;
            BS_CHECK: state_next = BS_READ;
            BS_DONE:  if (!out_valid_reg || rsp_ready) state_next = BS_IDLE;
            default:  state_next = BS_IDLE;
        endcase
    end

    always_comb
    begin
        status_next = ST_OK;
        total_next  = total_reg;
        value_next  = '0;
        unique case (cur_reg.operation)
            OP_INSERT:
            begin
                if (hit_reg)
                begin
                    status_next = ST_PRESENT;
                end
                else if (!free_reg)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    total_next = total_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (!hit_reg)
                begin
                    status_next = ST_ABSENT;
                end
                else
                begin
                    total_next = total_reg - 1'b1;
                end
            end
            default:
            begin
                if (!hit_reg)
                begin
                    status_next = ST_ABSENT;
                end
                else
                begin
                    value_next = val_mem_hit_reg;
                end
            end
        endcase
    end

    always_comb
    begin
        work_pop  = (state_reg == BS_IDLE) && !work_empty;
        rsp_valid = out_valid_reg;
        rsp       = out_reg;
        issue     = (state_reg == BS_DONE) && (!out_valid_reg || rsp_ready);
        do_insert = issue && (cur_reg.operation == OP_INSERT) && !hit_reg && free_reg;
        do_remove = issue && (cur_reg.operation == OP_REMOVE) && hit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BS_READ)
        begin
            rd_key_reg  <= key_mem[cur_slot];
            rd_val_reg  <= val_mem[cur_slot];
        end
        if (do_insert)
        begin
            key_mem[free_slot_reg] <= cur_reg.key;
            val_mem[free_slot_reg] <= cur_reg.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BS_READ)
        begin
            rd_valid_reg <= valid_mem[cur_slot];
        end
        if (state_reg == BS_CLEAR)
        begin
            valid_mem[clr_reg] <= 1'b0;
        end
        else if (do_insert)
        begin
            valid_mem[free_slot_reg] <= 1'b1;
        end
        else if (do_remove)
        begin
            valid_mem[hit_slot_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BS_IDLE)
        begin
            cur_reg  <= work;
            base_reg <= SW'(work.bucket) * SW'(CHAIN_DEPTH);
        end
        if (state_reg == BS_READ)
        begin
            rd_slot_reg <= cur_slot;
        end
    end

    // Value of the first matching slot, captured during the scan.
    always_ff @(posedge clk)
    begin
        if (state_reg == BS_CHECK && scan_match && !hit_reg)
        begin
            val_mem_hit_reg <= rd_val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_CLEAR;
            clr_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            hit_slot_reg  <= '0;
            free_slot_reg <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                BS_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                BS_IDLE:
                begin
                    idx_reg  <= '0;
                    hit_reg  <= 1'b0;
                    free_reg <= 1'b0;
                end
                BS_READ:
                begin
                end
                BS_WAIT:
                begin
                end
                BS_CHECK:
                begin
                    if (rd_valid_reg)
                    begin
                        if (!hit_reg && scan_match)
                        begin
                            hit_reg      <= 1'b1;
                            hit_slot_reg <= rd_slot_reg;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_reg      <= 1'b1;
                        free_slot_reg <= rd_slot_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                BS_DONE:
                begin
                    if (issue)
                    begin
                        out_reg.status       <= status_next;
                        out_reg.found        <= hit_reg;
                        out_reg.bucket_index <= cur_reg.bucket[5:0];
                        out_reg.value_out    <= value_next;
                        out_reg.entry_count  <= 10'(total_next);
                        total_reg            <= total_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    a_ins_rem: assert property (@(posedge clk) disable iff (!rst_n)
        !(do_insert && do_remove)) else $error("insert and remove together");
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> total_reg == $past(total_reg) + 1'b1) else $error("total not raised");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp_ready) |=> $stable(out_reg)) else $error("result changed");

endmodule

/* sv/universal_hash_table_engine.sv */
// Top level of the universal hash key/value table engine.
// The front end reduces a mod p and b mod p one source bit at a time, then runs the multiply
// (skipped when the modulus is zero) and the reduction to the bucket; the back end scans the chain.
// The front end takes a new request once it has pushed the last one into the queue, so it overlaps the back end.
// Reset: registers return to defaults; the slot valid marks are cleared by a pass over all
// NUM_BUCKETS*CHAIN_DEPTH slots (512 by default) before the first request reaches the table.
module universal_hash_table_engine #(
    parameter int NUM_BUCKETS = uhte_pkg::NUM_BUCKETS_DEF,
    parameter int CHAIN_DEPTH = uhte_pkg::CHAIN_DEPTH_DEF,
    parameter int KEY_BITS    = uhte_pkg::KEY_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  uhte_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output uhte_pkg::rsp_t  out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [63:0]     cfg_data
);
    import uhte_pkg::*;

    logic [63:0] mult_a_reg;
    logic [63:0] add_b_reg;
    logic [63:0] prime_p_reg;
    logic [6:0]  buckets_reg;

    logic  work_push;
    logic  work_pop;
    logic  work_full;
    logic  work_empty;
    work_t work_in;
    work_t work_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_a_reg  <= RESET_MULT_A;
            add_b_reg   <= RESET_ADD_B;
            prime_p_reg <= RESET_PRIME_P;
            buckets_reg <= RESET_BUCKETS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MULT_A:  mult_a_reg  <= cfg_data;
                CFG_ADD_B:   add_b_reg   <= cfg_data;
                CFG_PRIME_P: prime_p_reg <= cfg_data;
                CFG_BUCKETS: buckets_reg <= cfg_data[6:0];
                default:     ;
            endcase
        end
    end

    uhte_hash #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .KEY_BITS(KEY_BITS)
    ) u_hash (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(in_valid),
        .req_ready(in_ready),
        .req(in_data),
        .mult_a(mult_a_reg),
        .add_b(add_b_reg),
        .prime_p(prime_p_reg),
        .buckets(buckets_reg),
        .work_push(work_push),
        .work(work_in),
        .work_full(work_full)
    );

    uhte_fifo #(
        .DEPTH(2)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(work_push),
        .din(work_in),
        .full(work_full),
        .pop(work_pop),
        .dout(work_out),
        .empty(work_empty)
    );

    uhte_table #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .CHAIN_DEPTH(CHAIN_DEPTH)
    ) u_table (
        .clk(clk),
        .rst_n(rst_n),
        .work_empty(work_empty),
        .work(work_out),
        .work_pop(work_pop),
        .rsp_valid(out_valid),
        .rsp_ready(out_ready),
        .rsp(out_data)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result beat dropped");

endmodule
